// ===== rtl/core/stq_pkg.sv =====
// Shared types, widths and codes for the sorted timeout queue.
// Used by every module of the block except stq_ram; depends on nothing.
package stq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 64;
    localparam int THR_W       = 8;
    localparam int BT_W        = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    localparam logic [BT_W-1:0] BLOCK_TIME_RESET = 32'd1_000_000_000;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXPIRE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INFINITE    = 2'd3;

    typedef logic t_alu_op;
    localparam t_alu_op ALU_ADD = 1'b0;
    localparam t_alu_op ALU_SUB = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [THR_W-1:0]  thread;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [THR_W-1:0]    thread_index_res;
        logic                woken;
        logic                timed_out;
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   next_wake;
        logic                last;
    } t_result;

endpackage

// ===== rtl/core/stq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; the read data holds while no read is enabled.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/stq_alu.sv =====
// Shared 64-bit add/subtract unit; bit 64 of the result is carry or borrow.
// Depends on stq_pkg for the time width and operation codes.
module stq_alu
    import stq_pkg::*;
(
    input  t_alu_op           i_op,
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    output logic [TIME_W:0]   o_res
);

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_res = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: o_res = {1'b0, i_a} - {1'b0, i_b};
        endcase
    end

endmodule

// ===== rtl/core/stq_ctrl.sv =====
// Sequencer of the sorted timeout queue: walks the entry RAM one entry per cycle unless
// the output stalls; drives the shared ALU. Depends on stq_pkg, stq_ram, stq_alu.
module stq_ctrl
    import stq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [THR_W-1:0]    i_thr,
    input  logic [TIME_W-1:0]   i_wake,
    input  logic [TIME_W-1:0]   i_now,
    input  logic [BT_W-1:0]     i_block_time,
    output logic                o_res_valid,
    output t_result             o_res,
    input  logic                i_res_ready
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_INS_RD    = 4'd2;
    localparam logic [3:0] S_INS_PUT   = 4'd3;
    localparam logic [3:0] S_RM_RD     = 4'd4;
    localparam logic [3:0] S_EXP_SCAN  = 4'd5;
    localparam logic [3:0] S_EXP_MIN   = 4'd6;
    localparam logic [3:0] S_EXP_FIRST = 4'd7;
    localparam logic [3:0] S_EXP_OUT   = 4'd8;
    localparam logic [3:0] S_EXP_CP    = 4'd9;
    localparam logic [3:0] S_EMIT      = 4'd10;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_src, n_src;
    logic [CNT_W-1:0]  r_due, n_due;
    logic              r_found, n_found;
    logic [CMD_W-1:0]  r_cmd;
    logic [THR_W-1:0]  r_thr;
    logic [TIME_W-1:0] r_wake;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_next, n_next;
    logic [TIME_W-1:0] r_head, n_head;
    t_result           r_res, n_res;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    t_entry             ram_wdata, ram_rdata;
    t_entry             new_entry;

    t_alu_op            alu_op;
    logic [TIME_W-1:0]  alu_a, alu_b;
    logic [TIME_W:0]    alu_res;
    logic               alu_flag;
    logic [TIME_W-1:0]  sat_sum;
    logic               accept;
    logic               rm_hit;
    logic               rm_found_now;
    logic               exp_last;
    t_result            res_insert_ok;

    stq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    stq_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    assign alu_flag  = alu_res[TIME_W];
    assign sat_sum   = alu_flag ? '1 : alu_res[TIME_W-1:0];
    assign accept    = i_valid && (r_state == S_IDLE);
    assign o_ready   = (r_state == S_IDLE);
    assign new_entry = '{deadline: r_wake, thread: r_thr};
    assign rm_hit    = !r_found && (ram_rdata.thread == r_thr);
    assign rm_found_now = r_found || rm_hit;
    assign exp_last  = (r_idx == r_due - CNT_ONE);

    assign res_insert_ok = '{thread_index_res: '0, woken: 1'b0, timed_out: 1'b0,
                             status: ST_OK, next_wake: '0, last: 1'b1};

    // Operand selection for the shared unit. A borrow on a subtract means a < b.
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = r_now;
        alu_b  = {{(TIME_W-BT_W){1'b0}}, i_block_time};
        unique case (r_state)
            S_INS_RD: begin
                alu_op = ALU_SUB;
                alu_a  = r_wake;
                alu_b  = ram_rdata.deadline;
            end
            S_EXP_SCAN: begin
                alu_op = ALU_SUB;
                alu_a  = r_now;
                alu_b  = ram_rdata.deadline;
            end
            S_EXP_MIN: begin
                alu_op = ALU_SUB;
                alu_a  = r_head;
                alu_b  = r_next;
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_src       = r_src;
        n_due       = r_due;
        n_found     = r_found;
        n_next      = r_next;
        n_head      = r_head;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[ADDR_W-1:0];
        ram_wdata   = new_entry;
        ram_re      = 1'b0;
        ram_raddr   = r_idx[ADDR_W-1:0];
        o_res_valid = 1'b0;
        o_res       = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                case (r_cmd)
                    CMD_INSERT: begin
                        n_res = res_insert_ok;
                        if (&r_wake) begin
                            n_res.status = ST_INFINITE;
                            n_state      = S_EMIT;
                        end else if (r_count == CNT_FULL) begin
                            n_res.status = ST_FULL;
                            n_state      = S_EMIT;
                        end else if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            n_count   = CNT_ONE;
                            n_state   = S_EMIT;
                        end else begin
                            // Walk from the tail, shifting later deadlines up by one.
                            ram_re    = 1'b1;
                            ram_raddr = ADDR_W'(r_count - CNT_ONE);
                            n_idx     = r_count;
                            n_state   = S_INS_RD;
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_count == '0) begin
                            n_res = '{thread_index_res: '0, woken: 1'b0, timed_out: 1'b0,
                                      status: ST_NOT_PRESENT, next_wake: '0, last: 1'b1};
                            n_state = S_EMIT;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_found   = 1'b0;
                            n_state   = S_RM_RD;
                        end
                    end
                    CMD_EXPIRE: begin
                        n_next = sat_sum;
                        if (r_count == '0) begin
                            n_due   = '0;
                            n_state = S_EXP_FIRST;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_EXP_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_INS_RD: begin
                // Read data is the entry just below r_idx.
                if (alu_flag) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    if (r_idx == CNT_ONE) begin
                        n_idx   = '0;
                        n_state = S_INS_PUT;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(r_idx - CNT_TWO);
                        n_idx     = r_idx - CNT_ONE;
                    end
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + CNT_ONE;
                    n_res   = res_insert_ok;
                    n_state = S_EMIT;
                end
            end

            S_INS_PUT: begin
                ram_we  = 1'b1;
                n_count = r_count + CNT_ONE;
                n_res   = res_insert_ok;
                n_state = S_EMIT;
            end

            S_RM_RD: begin
                // Once the match is found, each later entry moves down one slot.
                if (r_found) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(r_idx - CNT_ONE);
                    ram_wdata = ram_rdata;
                end
                if (r_idx == r_count - CNT_ONE) begin
                    if (rm_found_now) begin
                        n_count = r_count - CNT_ONE;
                        n_res   = '{thread_index_res: r_thr, woken: 1'b1, timed_out: 1'b0,
                                    status: ST_OK, next_wake: '0, last: 1'b1};
                    end else begin
                        n_res   = '{thread_index_res: '0, woken: 1'b0, timed_out: 1'b0,
                                    status: ST_NOT_PRESENT, next_wake: '0, last: 1'b1};
                    end
                    n_state = S_EMIT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(r_idx + CNT_ONE);
                    n_idx     = r_idx + CNT_ONE;
                    n_found   = rm_found_now;
                end
            end

            S_EXP_SCAN: begin
                if (alu_flag) begin
                    n_due   = r_idx;
                    n_head  = ram_rdata.deadline;
                    n_state = S_EXP_MIN;
                end else if (r_idx == r_count - CNT_ONE) begin
                    n_due   = r_count;
                    n_state = S_EXP_FIRST;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(r_idx + CNT_ONE);
                    n_idx     = r_idx + CNT_ONE;
                end
            end

            S_EXP_MIN: begin
                if (alu_flag) begin
                    n_next = r_head;
                end
                n_state = S_EXP_FIRST;
            end

            S_EXP_FIRST: begin
                if (r_due == '0) begin
                    n_res = '{thread_index_res: '0, woken: 1'b0, timed_out: 1'b0,
                              status: ST_OK, next_wake: r_next, last: 1'b1};
                    n_state = S_EMIT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                    n_idx     = '0;
                    n_state   = S_EXP_OUT;
                end
            end

            S_EXP_OUT: begin
                o_res_valid = 1'b1;
                o_res = '{thread_index_res: ram_rdata.thread, woken: 1'b1, timed_out: 1'b1,
                          status: ST_OK, next_wake: r_next, last: exp_last};
                if (i_res_ready) begin
                    if (!exp_last) begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(r_idx + CNT_ONE);
                        n_idx     = r_idx + CNT_ONE;
                    end else if (r_due == r_count) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        // Move the surviving entries down to the head.
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(r_due);
                        n_src     = r_due;
                        n_idx     = '0;
                        n_state   = S_EXP_CP;
                    end
                end
            end

            S_EXP_CP: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (r_src == r_count - CNT_ONE) begin
                    n_count = r_count - r_due;
                    n_state = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(r_src + CNT_ONE);
                    n_src     = r_src + CNT_ONE;
                    n_idx     = r_idx + CNT_ONE;
                end
            end

            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_src  <= n_src;
        r_due  <= n_due;
        r_next <= n_next;
        r_head <= n_head;
        r_res  <= n_res;
        if (accept) begin
            r_cmd  <= i_cmd;
            r_thr  <= i_thr;
            r_wake <= i_wake;
            r_now  <= i_now;
        end
    end

endmodule

// ===== rtl/core/sorted_timeout_queue.sv =====
// Top level of the sorted timeout queue: stream ports, block time register
// and output register. Depends on stq_pkg and stq_ctrl.

// Keeps up to QUEUE_DEPTH sleeping threads in deadline order in one entry RAM
// that the sequencer reads and writes one entry per cycle unless the output
// stalls. Insert walks from the tail and remove walks from the head. Expire
// scans the due entries, emits one item per due entry and then moves the rest
// to the head, or emits a single item when none is due; emitted items also
// wait on the output side. Entries need no clearing after reset. The block
// takes one input item at a time and is ready again once the last result is
// handed to the output register and any remaining entries are moved.
module sorted_timeout_queue
    import stq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [7:0] thread_index, [71:8] wakeup_time, [135:72] current_time
    input  logic [135:0]  s_axis_tdata,
    // [1:0] command
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [7:0] thread_index_res, [8] woken, [9] timed_out, [11:10] status,
    // [75:12] next_wake, [79:76] zero
    output logic [79:0]   m_axis_tdata,
    output logic          m_axis_tlast,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata
);

    logic [BT_W-1:0] r_block_time;
    logic            r_out_valid;
    t_result         r_out;
    logic            res_valid;
    logic            res_ready;
    t_result         res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_time <= BLOCK_TIME_RESET;
        end else if (i_cfg_we) begin
            r_block_time <= i_cfg_wdata;
        end
    end

    stq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_thr        (s_axis_tdata[7:0]),
        .i_wake       (s_axis_tdata[71:8]),
        .i_now        (s_axis_tdata[135:72]),
        .i_block_time (r_block_time),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {4'b0, r_out.next_wake, r_out.status, r_out.timed_out,
                            r_out.woken, r_out.thread_index_res};

endmodule
